// File: src/wssf_pkg.sv
// Package for the weight smoothing and stability filter.
// Holds shared widths, register codes, reset values and the configuration struct.
// No dependencies.
`default_nettype none

package wssf_pkg;

	// Sample and result width, 1/16 gram units
	localparam int WEIGHT_W = 32;

	// Averaging taps; must be a power of two so the mean is an arithmetic shift
	localparam int AVG_TAPS  = 2;
	localparam int AVG_SHIFT = $clog2(AVG_TAPS);
	localparam int SUM_W     = WEIGHT_W + AVG_SHIFT;

	// Smoother arithmetic widths
	localparam int COEF_W = 18;
	localparam int PROD_W = COEF_W + WEIGHT_W;
	localparam int MIX_W  = PROD_W + 1;
	localparam int FRAC_W = 16;

	// Stable counter
	localparam int CNT_W = 4;

	// APB register map
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_ALPHA     = 2'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [IDX_W-1:0] REG_LIMIT     = 2'd2;

	localparam logic [15:0]      ALPHA_RESET     = 16'd42598;
	localparam logic [15:0]      THRESHOLD_RESET = 16'd48;
	localparam logic [CNT_W-1:0] LIMIT_RESET     = 4'd2;

	typedef struct packed {
		logic [15:0]      alpha;
		logic [15:0]      threshold;
		logic [CNT_W-1:0] limit;
	} cfg_t;

endpackage

`default_nettype wire

// File: src/wssf_cfg.sv
// APB register block for the filter: smoothing weight, stability threshold and limit.
// Depends on wssf_pkg.
`default_nettype none

module wssf_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wssf_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [wssf_pkg::DATA_W-1:0]  pwdata,
	output logic      [wssf_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output wssf_pkg::cfg_t                    cfg
);

	wssf_pkg::cfg_t cfg_q;
	logic [wssf_pkg::IDX_W-1:0] idx;
	logic wr_en;

	assign idx    = paddr[wssf_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write a register on the access phase; unknown addresses are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha     <= wssf_pkg::ALPHA_RESET;
			cfg_q.threshold <= wssf_pkg::THRESHOLD_RESET;
			cfg_q.limit     <= wssf_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				wssf_pkg::REG_ALPHA:     cfg_q.alpha     <= pwdata[15:0];
				wssf_pkg::REG_THRESHOLD: cfg_q.threshold <= pwdata[15:0];
				wssf_pkg::REG_LIMIT:     cfg_q.limit     <= pwdata[wssf_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			wssf_pkg::REG_ALPHA:     prdata = {16'd0, cfg_q.alpha};
			wssf_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold};
			wssf_pkg::REG_LIMIT:
				prdata = {{(wssf_pkg::DATA_W-wssf_pkg::CNT_W){1'b0}}, cfg_q.limit};
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/wssf_mean.sv
// Input stage: sample history taps and the running mean register.
// Depends on wssf_pkg.
`default_nettype none

module wssf_mean (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [wssf_pkg::WEIGHT_W-1:0] raw_weight,
	output logic                                     mean_valid,
	input  wire logic                                mean_free,
	output logic signed [wssf_pkg::WEIGHT_W-1:0]     mean
);

	logic signed [wssf_pkg::WEIGHT_W-1:0] taps_q   [wssf_pkg::AVG_TAPS];
	logic signed [wssf_pkg::WEIGHT_W-1:0] taps_nxt [wssf_pkg::AVG_TAPS];
	logic signed [wssf_pkg::SUM_W-1:0]    sum;
	logic signed [wssf_pkg::SUM_W-1:0]    sum_sh;
	logic signed [wssf_pkg::WEIGHT_W-1:0] mean_s1;
	logic                                 valid_s1;
	logic                                 accept;

	// Stage 1 can take a sample when empty or when its item moves on
	assign in_ready = !valid_s1 || mean_free;
	assign accept   = in_valid && in_ready;

	// Shift the new sample into the taps and add them all up
	always_comb begin
		taps_nxt[0] = raw_weight;
		for (int i = 1; i < wssf_pkg::AVG_TAPS; i++) begin
			taps_nxt[i] = taps_q[i-1];
		end
		sum = '0;
		for (int i = 0; i < wssf_pkg::AVG_TAPS; i++) begin
			sum = sum + wssf_pkg::SUM_W'(taps_nxt[i]);
		end
		sum_sh = sum >>> wssf_pkg::AVG_SHIFT;
	end

	// Hold the taps; reset clears the history to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wssf_pkg::AVG_TAPS; i++) begin
				taps_q[i] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				for (int i = 0; i < wssf_pkg::AVG_TAPS; i++) begin
					taps_q[i] <= taps_nxt[i];
				end
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// Floored mean of the taps
	always_ff @(posedge clk) begin
		if (accept) begin
			mean_s1 <= sum_sh[wssf_pkg::WEIGHT_W-1:0];
		end
	end

	assign mean_valid = valid_s1;
	assign mean       = mean_s1;

endmodule

`default_nettype wire

// File: src/wssf_smooth.sv
// Exponential smoother stage: blends the mean into the smoothed value, Q0.16 weight.
// Depends on wssf_pkg.
`default_nettype none

module wssf_smooth (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 mean_valid,
	output logic                                      mean_free,
	input  wire logic signed [wssf_pkg::WEIGHT_W-1:0] mean,
	input  wire logic [15:0]                          alpha,
	output logic                                      smooth_valid,
	input  wire logic                                 smooth_free,
	output logic signed [wssf_pkg::WEIGHT_W-1:0]      smooth_value,
	output logic signed [wssf_pkg::WEIGHT_W-1:0]      prior_value
);

	logic signed [wssf_pkg::WEIGHT_W-1:0] smoothed_q;
	logic signed [wssf_pkg::WEIGHT_W-1:0] smooth_s2;
	logic signed [wssf_pkg::WEIGHT_W-1:0] prior_s2;
	logic                                 valid_s2;
	logic signed [wssf_pkg::COEF_W-1:0]   alpha_c;
	logic signed [wssf_pkg::COEF_W-1:0]   keep_c;
	logic signed [wssf_pkg::PROD_W-1:0]   prod_new;
	logic signed [wssf_pkg::PROD_W-1:0]   prod_old;
	logic signed [wssf_pkg::MIX_W-1:0]    mixed;
	logic signed [wssf_pkg::WEIGHT_W-1:0] smoothed_nxt;
	logic                                 load;

	assign mean_free = smooth_free;
	assign load      = mean_valid && smooth_free;

	// Weighted blend of the new mean and the held value, floored by the shift
	always_comb begin
		alpha_c      = {2'b00, alpha};
		keep_c       = wssf_pkg::COEF_W'(65536) - alpha_c;
		prod_new     = wssf_pkg::PROD_W'(alpha_c) * wssf_pkg::PROD_W'(mean);
		prod_old     = wssf_pkg::PROD_W'(keep_c) * wssf_pkg::PROD_W'(smoothed_q);
		mixed        = wssf_pkg::MIX_W'(prod_new) + wssf_pkg::MIX_W'(prod_old);
		smoothed_nxt = mixed[wssf_pkg::FRAC_W +: wssf_pkg::WEIGHT_W];
	end

	// Smoother state and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			valid_s2   <= 1'b0;
		end else begin
			if (load) begin
				smoothed_q <= smoothed_nxt;
			end
			if (smooth_free) begin
				valid_s2 <= mean_valid;
			end
		end
	end

	// Carry the new and previous smoothed values to the stability check
	always_ff @(posedge clk) begin
		if (load) begin
			smooth_s2 <= smoothed_nxt;
			prior_s2  <= smoothed_q;
		end
	end

	assign smooth_valid = valid_s2;
	assign smooth_value = smooth_s2;
	assign prior_value  = prior_s2;

endmodule

`default_nettype wire

// File: src/wssf_stable.sv
// Stability check: change magnitude against threshold, stable counter, result register.
// Depends on wssf_pkg.
`default_nettype none

module wssf_stable (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 smooth_valid,
	output logic                                      smooth_free,
	input  wire logic signed [wssf_pkg::WEIGHT_W-1:0] smooth_value,
	input  wire logic signed [wssf_pkg::WEIGHT_W-1:0] prior_value,
	input  wire logic [15:0]                          threshold,
	input  wire logic [wssf_pkg::CNT_W-1:0]           limit,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [wssf_pkg::WEIGHT_W-1:0]      stable_weight
);

	localparam logic [wssf_pkg::CNT_W-1:0] CNT_MAX = '1;

	logic signed [wssf_pkg::WEIGHT_W:0]   diff;
	logic        [wssf_pkg::WEIGHT_W:0]   mag;
	logic                                 stable;
	logic        [wssf_pkg::CNT_W-1:0]    count_q;
	logic        [wssf_pkg::CNT_W-1:0]    count_nxt;
	logic                                 emit;
	logic                                 out_free;
	logic                                 move;
	logic                                 out_valid_q;
	logic signed [wssf_pkg::WEIGHT_W-1:0] weight_q;

	// Absolute change against the threshold, then the saturating count
	always_comb begin
		diff   = (wssf_pkg::WEIGHT_W+1)'(smooth_value) - (wssf_pkg::WEIGHT_W+1)'(prior_value);
		mag    = diff[wssf_pkg::WEIGHT_W] ? -diff : diff;
		stable = mag < {{(wssf_pkg::WEIGHT_W-15){1'b0}}, threshold};
		if (!stable) begin
			count_nxt = '0;
		end else if (count_q == CNT_MAX) begin
			count_nxt = count_q;
		end else begin
			count_nxt = count_q + wssf_pkg::CNT_W'(1);
		end
		emit = count_nxt >= limit;
	end

	// An item leaves stage 2 unless its result finds the output register full
	assign out_free    = !out_valid_q || out_ready;
	assign move        = smooth_valid && (!emit || out_free);
	assign smooth_free = !smooth_valid || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (move) begin
				count_q <= emit ? '0 : count_nxt;
			end
			if (move && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register: load on emit, hold while the receiver stalls
	always_ff @(posedge clk) begin
		if (move && emit) begin
			weight_q <= smooth_value;
		end
	end

	assign out_valid     = out_valid_q;
	assign stable_weight = weight_q;

endmodule

`default_nettype wire

// File: src/weight_smooth_stability_filter_core.sv
// Top level of the load-cell weight smoothing and stability filter.
// Depends on wssf_pkg, wssf_cfg, wssf_mean, wssf_smooth and wssf_stable.
//
// Usage:
//   Input channel in_valid/in_ready carries raw_weight, signed 1/16 gram.
//   Output channel out_valid/out_ready carries stable_weight; a sample gives
//   at most one result, only once the smoothed value has stayed within the
//   threshold for the configured number of samples.
//   APB port holds smoothing_alpha (0x0), stable_threshold (0x4) and
//   stable_limit (0x8); pready is tied high, writes take effect at the access
//   phase and should be made only while the filter is idle.
// Timing:
//   Three register stages: mean, smoother, result register. A sample's result
//   is registered in each in turn before it shows on out_valid. One sample is
//   taken every cycle while in_ready is high; the smoother loop closes through
//   two 18x32 multipliers and an add.
// Reset: arst_n clears the history taps, smoothed value, stable count and all
//   valids, and loads the register defaults.
// Stall: while a result waits, stages behind it keep filling; in_ready drops
//   only when every stage holds an item and the head one has a result to give.
`default_nettype none

module weight_smooth_stability_filter_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [wssf_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [wssf_pkg::DATA_W-1:0]          pwdata,
	output logic      [wssf_pkg::DATA_W-1:0]          prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [wssf_pkg::WEIGHT_W-1:0] raw_weight,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [wssf_pkg::WEIGHT_W-1:0]      stable_weight
);

	wssf_pkg::cfg_t                       cfg;
	logic                                 mean_valid;
	logic                                 mean_free;
	logic signed [wssf_pkg::WEIGHT_W-1:0] mean;
	logic                                 smooth_valid;
	logic                                 smooth_free;
	logic signed [wssf_pkg::WEIGHT_W-1:0] smooth_value;
	logic signed [wssf_pkg::WEIGHT_W-1:0] prior_value;

	// Configuration registers
	wssf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1: history taps and mean
	wssf_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_weight (raw_weight),
		.mean_valid (mean_valid),
		.mean_free  (mean_free),
		.mean       (mean)
	);

	// Stage 2: exponential smoother
	wssf_smooth u_smooth (
		.clk          (clk),
		.arst_n       (arst_n),
		.mean_valid   (mean_valid),
		.mean_free    (mean_free),
		.mean         (mean),
		.alpha        (cfg.alpha),
		.smooth_valid (smooth_valid),
		.smooth_free  (smooth_free),
		.smooth_value (smooth_value),
		.prior_value  (prior_value)
	);

	// Stage 3: stability count and result register
	wssf_stable u_stable (
		.clk           (clk),
		.arst_n        (arst_n),
		.smooth_valid  (smooth_valid),
		.smooth_free   (smooth_free),
		.smooth_value  (smooth_value),
		.prior_value   (prior_value),
		.threshold     (cfg.threshold),
		.limit         (cfg.limit),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stable_weight (stable_weight)
	);

	// A transferred sample always lands in the mean stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> mean_valid)
		else $error("accepted sample missing from mean stage");

	// A blocked smoother item holds its value
	a_smooth_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smooth_valid && !smooth_free |=> smooth_valid && $stable(smooth_value))
		else $error("stalled smoother item changed");

	// A taken result is not shown again without a new item behind it
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !smooth_valid |=> !out_valid)
		else $error("result repeated after transfer");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for weight_smooth_stability_filter_core.
// Drives weight samples and register writes, and predicts each stable_weight
// result in step. Depends on wssf_pkg and the filter RTL.

module tb_top;

	localparam logic [wssf_pkg::IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam int                         SETTLE_PAD  = 8;
	localparam int                         STALL_LIMIT = 4000;
	localparam int                         REPORT_MAX  = 10;

	logic                                 clk        = 1'b0;
	logic                                 arst_n     = 1'b0;
	logic                                 psel       = 1'b0;
	logic                                 penable    = 1'b0;
	logic                                 pwrite     = 1'b0;
	logic [wssf_pkg::ADDR_W-1:0]          paddr      = '0;
	logic [wssf_pkg::DATA_W-1:0]          pwdata     = '0;
	logic [wssf_pkg::DATA_W-1:0]          prdata;
	logic                                 pready;
	logic                                 in_valid   = 1'b0;
	logic                                 in_ready;
	logic signed [wssf_pkg::WEIGHT_W-1:0] raw_weight = '0;
	logic                                 out_valid;
	logic                                 out_ready  = 1'b0;
	logic signed [wssf_pkg::WEIGHT_W-1:0] stable_weight;

	// Stimulus and scoreboard storage
	logic signed [wssf_pkg::WEIGHT_W-1:0] sample_feed[$];
	logic signed [wssf_pkg::WEIGHT_W-1:0] weight_due[$];
	logic signed [wssf_pkg::WEIGHT_W-1:0] due_weight;
	int                                   idle_pct    = 9;
	int                                   mismatches  = 0;
	int                                   quiet_ticks = 0;

	// Shadow of the filter state and its registers
	wssf_pkg::cfg_t filt_cfg = '{alpha: wssf_pkg::ALPHA_RESET,
	                             threshold: wssf_pkg::THRESHOLD_RESET,
	                             limit: wssf_pkg::LIMIT_RESET};
	logic signed [wssf_pkg::WEIGHT_W-1:0] tap_ring[wssf_pkg::AVG_TAPS] = '{default: '0};
	logic                                 tap_slot   = 1'b0;
	logic signed [wssf_pkg::WEIGHT_W-1:0] ema_now    = '0;
	logic signed [wssf_pkg::WEIGHT_W-1:0] ema_last   = '0;
	logic [wssf_pkg::CNT_W-1:0]           calm_count = '0;

	weight_smooth_stability_filter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_weight(raw_weight),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stable_weight(stable_weight)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the shadow filter by one sample and queue any emitted weight
	task automatic filter_sample(input logic signed [wssf_pkg::WEIGHT_W-1:0] sample);
		logic signed [wssf_pkg::WEIGHT_W:0]   tap_sum;
		logic signed [wssf_pkg::WEIGHT_W-1:0] tap_mean;
		logic signed [63:0]                   w_new, w_old, mean64, ema64, blend, change, limit64;
		tap_ring[tap_slot] = sample;
		tap_slot = ~tap_slot;
		tap_sum  = (wssf_pkg::WEIGHT_W+1)'(tap_ring[0]) + (wssf_pkg::WEIGHT_W+1)'(tap_ring[1]);
		tap_mean = wssf_pkg::WEIGHT_W'(tap_sum >>> 1);
		w_new  = {48'd0, filt_cfg.alpha};
		w_old  = 64'sd65536 - w_new;
		mean64 = 64'(tap_mean);
		ema64  = 64'(ema_now);
		blend  = w_new * mean64 + w_old * ema64;
		ema_now = wssf_pkg::WEIGHT_W'(blend >>> wssf_pkg::FRAC_W);
		change = 64'(ema_now) - 64'(ema_last);
		if (change < 0)
			change = -change;
		limit64 = {48'd0, filt_cfg.threshold};
		// count saturates at its ceiling, clears on any large move
		if (change < limit64) begin
			if (calm_count != '1)
				calm_count = calm_count + wssf_pkg::CNT_W'(1);
		end else begin
			calm_count = '0;
		end
		ema_last = ema_now;
		if (calm_count >= filt_cfg.limit) begin
			calm_count = '0;
			weight_due.push_back(ema_now);
		end
	endtask

	// Sample driver: hold each item until its transfer, gap at random
	always @(posedge clk) begin
		if (in_valid && in_ready)
			filter_sample(raw_weight);
		if (!in_valid || in_ready) begin
			if (sample_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid   <= 1'b1;
				raw_weight <= sample_feed.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expected weight
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (weight_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected stable_weight %0d", stable_weight);
			end else begin
				due_weight = weight_due.pop_front();
				if (stable_weight !== due_weight) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("stable_weight mismatch: expected %0d, got %0d",
							due_weight, stable_weight);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_ticks <= 0;
		else
			quiet_ticks <= quiet_ticks + 1;
		if (quiet_ticks >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Register write: setup then access, shadow copy updated at the access edge
	task automatic write_reg(input logic [wssf_pkg::IDX_W-1:0] idx,
		input logic [wssf_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			wssf_pkg::REG_ALPHA:     filt_cfg.alpha     = val[15:0];
			wssf_pkg::REG_THRESHOLD: filt_cfg.threshold = val[15:0];
			wssf_pkg::REG_LIMIT:     filt_cfg.limit     = val[wssf_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Wait until every sample is taken and every result seen, then let the pipe empty
	task automatic settle();
		@(negedge clk);
		while (sample_feed.size() != 0 || in_valid || weight_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_PAD) @(negedge clk);
	endtask

	// Noisy readings around a base, with occasional jumps and wild samples
	task automatic feed_noisy(input int count);
		logic signed [wssf_pkg::WEIGHT_W-1:0] base;
		int unsigned                          spread;
		int                                   pick;
		base   = $urandom();
		spread = $urandom_range(1, 40);
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				case ($urandom_range(3))
					0: base = 32'h7FFF_FF00;
					1: base = 32'h8000_0100;
					2: base = $urandom_range(4000);
					default: base = $urandom();
				endcase
				spread = $urandom_range(1, 200);
			end
			if (pick >= 6 && pick < 14)
				sample_feed.push_back($urandom());
			else
				sample_feed.push_back(base + $urandom_range(2 * spread) - spread);
		end
	endtask

	initial begin : stimulus
		logic [15:0]                alpha_pick;
		logic [15:0]                thresh_pick;
		logic [wssf_pkg::CNT_W-1:0] limit_pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: field extremes and alternating signs
		sample_feed = '{32'sd0, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd1, 32'sd1,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
		settle();

		// Zero limit emits on every sample; full alpha, zero threshold
		write_reg(wssf_pkg::REG_LIMIT, 32'd0);
		write_reg(wssf_pkg::REG_ALPHA, 32'd65535);
		write_reg(wssf_pkg::REG_THRESHOLD, 32'd0);
		sample_feed = '{32'h8000_0000, 32'h7FFF_FFFF, -32'sd16, 32'sd16};
		settle();

		// Zero alpha freezes the smoothed value; build a count under the top limit
		write_reg(wssf_pkg::REG_ALPHA, 32'd0);
		write_reg(wssf_pkg::REG_THRESHOLD, 32'd65535);
		write_reg(wssf_pkg::REG_LIMIT, 32'd15);
		repeat (8) sample_feed.push_back($urandom());
		settle();

		// Lowered limit: count already above it, so the next sample emits
		write_reg(wssf_pkg::REG_LIMIT, 32'd3);
		sample_feed = '{32'sd100, -32'sd100};
		settle();

		// Upper bits ignored, unused address ignored
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		write_reg(wssf_pkg::REG_ALPHA, 32'hABCD_0001);
		write_reg(wssf_pkg::REG_THRESHOLD, 32'h1234_0030);
		write_reg(wssf_pkg::REG_LIMIT, 32'hFFFF_FFF1);
		sample_feed = '{32'sd4000, 32'sd4001, 32'sd3999};
		settle();

		// Random phases, each under its own register settings
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(5))
				0: alpha_pick = 16'd0;
				1: alpha_pick = 16'd65535;
				2: alpha_pick = wssf_pkg::ALPHA_RESET;
				default: alpha_pick = 16'($urandom());
			endcase
			case ($urandom_range(5))
				0: thresh_pick = 16'd0;
				1: thresh_pick = 16'd65535;
				default: thresh_pick = 16'($urandom_range(8, 2000));
			endcase
			case ($urandom_range(4))
				0: limit_pick = 4'd0;
				1: limit_pick = 4'd15;
				default: limit_pick = wssf_pkg::CNT_W'($urandom_range(1, 6));
			endcase
			write_reg(wssf_pkg::REG_ALPHA, {16'($urandom()), alpha_pick});
			write_reg(wssf_pkg::REG_THRESHOLD, {16'd0, thresh_pick});
			write_reg(wssf_pkg::REG_LIMIT, {28'd0, limit_pick});
			idle_pct = (phase == 5) ? 0 : 9;
			feed_noisy(30);
			// sender holds off until every pending result has come back
			if (phase == 2)
				settle();
			feed_noisy(30);
			settle();
		end
		idle_pct = 9;

		if (mismatches == 0 && weight_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
